>>> rtl/twa_pkg.sv
// Shared types and constants for the terminal word assembler.
// No dependencies; imported by every module of the block.
`default_nettype none

package twa_pkg;

  // Framing modes as written to the start mode register
  localparam logic [1:0] MODE_AUTO    = 2'd0;
  localparam logic [1:0] MODE_CLASSIC = 2'd1;
  localparam logic [1:0] MODE_ASCII   = 2'd2;

  localparam int unsigned ModeW     = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 20;
  localparam int unsigned QueueDepth = 4;

  // Auto-detect holds this many bytes before choosing the framing
  localparam int unsigned DetectDepth = 3;
  localparam int unsigned DetIdxW     = $clog2(DetectDepth);

  // Classic framing tags in the top two bits of a byte
  localparam logic [1:0] ClassicMidTag = 2'b10;
  localparam logic [1:0] ClassicLowTag = 2'b11;

  // Classic words with special meaning
  localparam logic [WordW-1:0] ClassicDelayWord = 20'd1;
  localparam logic [WordW-1:0] ClassicAbortWord = 20'd2;

  // ASCII framing constants
  localparam logic [ByteW-1:0] IacByte   = 8'o377;
  localparam logic [6:0]       EscChar   = 7'o033;
  localparam logic [6:0]       NulChar   = 7'o000;
  localparam logic [WordW-1:0] DelayCode = 20'h80000;

  // One queued byte on its way to the framing logic
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             classic;  // framing to apply
    logic             last;     // final byte of the accepted item
  } twa_entry_t;

endpackage

`default_nettype wire

>>> rtl/twa_queue.sv
// Short FIFO of framing entries between front and back end.
// Depends on twa_pkg for the entry type.
`default_nettype none

module twa_queue #(
  parameter int unsigned Depth = twa_pkg::QueueDepth
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_valid_i,
  output logic                push_ready_o,
  input  twa_pkg::twa_entry_t push_entry_i,
  output logic                pop_valid_o,
  input  wire                 pop_ready_i,
  output twa_pkg::twa_entry_t pop_entry_o
);
  import twa_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  twa_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/twa_front.sv
// Front end: accepts bytes, runs auto-detection and replays held bytes.
// Depends on twa_pkg; feeds twa_queue.
`default_nettype none

module twa_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_write_i,
  input  wire  [twa_pkg::ModeW-1:0]    cfg_mode_i,
  input  wire                          s_tvalid_i,
  output logic                         s_tready_o,
  input  wire  [twa_pkg::ByteW-1:0]    s_tdata_i,
  output logic                         push_valid_o,
  input  wire                          push_ready_i,
  output twa_pkg::twa_entry_t          push_entry_o
);
  import twa_pkg::*;

  typedef enum logic [2:0] {
    REP_IDLE   = 3'b001,
    REP_SECOND = 3'b010,
    REP_THIRD  = 3'b100
  } rep_e;

  localparam logic [DetIdxW-1:0] DetLastIdx = DetIdxW'(DetectDepth - 1);

  rep_e               rep_q, rep_d;
  logic [ModeW-1:0]   mode_q, mode_d;
  logic [DetIdxW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]   det_q [DetectDepth];
  logic               det_wr, accept, match, is_classic;

  assign s_tready_o = (rep_q == REP_IDLE) && push_ready_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign is_classic = (mode_q == MODE_CLASSIC);
  // Classic when the held bytes follow the first/middle/last tag pattern
  assign match = !det_q[0][7] && (det_q[1][7:6] == ClassicMidTag)
              && (s_tdata_i[7:6] == ClassicLowTag);

  always_comb begin
    rep_d        = rep_q;
    mode_d       = mode_q;
    cnt_d        = cnt_q;
    det_wr       = 1'b0;
    push_valid_o = 1'b0;
    push_entry_o = '{data: s_tdata_i, classic: is_classic, last: 1'b1};
    case (rep_q)
      REP_SECOND: begin
        push_valid_o = 1'b1;
        push_entry_o = '{data: det_q[1], classic: is_classic, last: 1'b0};
        if (push_ready_i) begin
          rep_d = REP_THIRD;
        end
      end
      REP_THIRD: begin
        push_valid_o = 1'b1;
        push_entry_o = '{data: det_q[2], classic: is_classic, last: 1'b1};
        if (push_ready_i) begin
          rep_d = REP_IDLE;
        end
      end
      default: begin
        if (accept) begin
          if (mode_q == MODE_AUTO) begin
            det_wr = 1'b1;
            if (cnt_q == DetLastIdx) begin
              // Framing decided: start the replay with the first held byte
              push_valid_o = 1'b1;
              push_entry_o = '{data: det_q[0], classic: match, last: 1'b0};
              mode_d       = match ? MODE_CLASSIC : MODE_ASCII;
              cnt_d        = '0;
              rep_d        = REP_SECOND;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end else begin
            push_valid_o = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q  <= REP_IDLE;
      mode_q <= MODE_AUTO;
      cnt_q  <= '0;
    end else if (cfg_write_i) begin
      rep_q  <= REP_IDLE;
      mode_q <= cfg_mode_i;
      cnt_q  <= '0;
    end else begin
      rep_q  <= rep_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (det_wr) begin
      det_q[cnt_q] <= s_tdata_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/twa_back.sv
// Back end: classic and ASCII framing, word stash and output register.
// Depends on twa_pkg; drains twa_queue.
`default_nettype none

module twa_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_write_i,
  input  wire                          pop_valid_i,
  output logic                         pop_ready_o,
  input  twa_pkg::twa_entry_t          pop_entry_i,
  output logic                         m_tvalid_o,
  input  wire                          m_tready_i,
  output logic [twa_pkg::WordW-1:0]    m_word_o,
  output logic                         m_abort_o,
  output logic                         m_classic_o,
  output logic                         m_last_o
);
  import twa_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_THIRD  = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    PFX_NONE = 3'b001,
    PFX_IAC  = 3'b010,
    PFX_ESC  = 3'b100
  } pfx_e;

  phase_e           phase_q, phase_d;
  pfx_e             pfx_q, pfx_d;
  logic [6:0]       high_q, high_d;
  logic [5:0]       mid_q, mid_d;
  logic [ByteW-1:0] b;
  logic [6:0]       c7;
  logic [WordW-1:0] raw;
  logic             wv, ab;
  logic [WordW-1:0] w;

  logic             stash_valid_q, stash_valid_d;
  logic [WordW-1:0] stash_word_q;
  logic             stash_abort_q, stash_classic_q;

  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_word_q;
  logic             out_abort_q, out_classic_q, out_last_q;

  logic             slot_free, consume, emit, emit_stash, emit_last, stash_load;

  assign b   = pop_entry_i.data;
  assign c7  = b[6:0];
  assign raw = {1'b0, high_q, mid_q, b[5:0]};

  // Framing decode of the entry at the queue head
  always_comb begin
    phase_d = phase_q;
    pfx_d   = pfx_q;
    high_d  = high_q;
    mid_d   = mid_q;
    wv      = 1'b0;
    ab      = 1'b0;
    w       = raw;
    if (pop_entry_i.classic) begin
      case (phase_q)
        PH_SECOND: begin
          if (b[7:6] == ClassicMidTag) begin
            mid_d   = b[5:0];
            phase_d = PH_THIRD;
          end else if (!b[7]) begin
            high_d = c7;
          end else begin
            phase_d = PH_FIRST;
          end
        end
        PH_THIRD: begin
          if (b[7:6] == ClassicLowTag) begin
            phase_d = PH_FIRST;
            wv      = 1'b1;
            if (raw == ClassicDelayWord) begin
              w = raw | DelayCode;
            end else begin
              ab = (raw == ClassicAbortWord);
            end
          end else if (!b[7]) begin
            high_d  = c7;
            phase_d = PH_SECOND;
          end else begin
            phase_d = PH_FIRST;
          end
        end
        default: begin
          if (!b[7]) begin
            high_d  = c7;
            phase_d = PH_SECOND;
          end else begin
            phase_d = PH_FIRST;
          end
        end
      endcase
    end else begin
      if ((pfx_q == PFX_NONE) && (b == IacByte)) begin
        pfx_d = PFX_IAC;
      end else if (c7 == EscChar) begin
        pfx_d = PFX_ESC;
      end else begin
        pfx_d = PFX_NONE;
        wv    = 1'b1;
        if (pfx_q == PFX_ESC) begin
          w = {5'd0, EscChar, 1'b0, c7};
        end else if (c7 == NulChar) begin
          w = DelayCode;
        end else begin
          w = {13'd0, c7};
        end
      end
    end
  end

  // A word waits in the stash until a later byte of the same item shows
  // whether it is the final one.
  assign slot_free = !out_valid_q || m_tready_i;

  always_comb begin
    consume       = 1'b0;
    emit          = 1'b0;
    emit_stash    = 1'b0;
    emit_last     = 1'b0;
    stash_load    = 1'b0;
    stash_valid_d = stash_valid_q;
    if (pop_valid_i) begin
      if (wv) begin
        if (stash_valid_q) begin
          // flush the stashed word first; hold the entry
          if (slot_free) begin
            emit          = 1'b1;
            emit_stash    = 1'b1;
            stash_valid_d = 1'b0;
          end
        end else if (pop_entry_i.last) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            consume   = 1'b1;
          end
        end else begin
          stash_load    = 1'b1;
          stash_valid_d = 1'b1;
          consume       = 1'b1;
        end
      end else if (pop_entry_i.last && stash_valid_q) begin
        if (slot_free) begin
          emit          = 1'b1;
          emit_stash    = 1'b1;
          emit_last     = 1'b1;
          stash_valid_d = 1'b0;
          consume       = 1'b1;
        end
      end else begin
        consume = 1'b1;
      end
    end
    out_valid_d = emit ? 1'b1 : (out_valid_q && !m_tready_i);
  end

  assign pop_ready_o = consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_FIRST;
      pfx_q         <= PFX_NONE;
      stash_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else if (cfg_write_i) begin
      phase_q       <= PH_FIRST;
      pfx_q         <= PFX_NONE;
      stash_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (consume) begin
        phase_q <= phase_d;
        pfx_q   <= pfx_d;
      end
      stash_valid_q <= stash_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      high_q <= high_d;
      mid_q  <= mid_d;
    end
    if (stash_load) begin
      stash_word_q    <= w;
      stash_abort_q   <= ab;
      stash_classic_q <= pop_entry_i.classic;
    end
    if (emit) begin
      out_word_q    <= emit_stash ? stash_word_q : w;
      out_abort_q   <= emit_stash ? stash_abort_q : ab;
      out_classic_q <= emit_stash ? stash_classic_q : pop_entry_i.classic;
      out_last_q    <= emit_last;
    end
  end

  assign m_tvalid_o  = out_valid_q;
  assign m_word_o    = out_word_q;
  assign m_abort_o   = out_abort_q;
  assign m_classic_o = out_classic_q;
  assign m_last_o    = out_last_q;

  // A byte that yields a word is never taken while another word is stashed
  a_no_stash_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_ready_o && wv) |-> !stash_valid_q)
    else $error("word consumed while stash occupied");

  // Taking the final byte of an item leaves nothing behind in the stash
  a_stash_empty_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_i && pop_ready_o && pop_entry_i.last && !cfg_write_i) |=> !stash_valid_q)
    else $error("stash left full at end of item");

  // The abort marker only accompanies the classic abort word
  a_abort_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_abort_q) |-> (out_classic_q && (out_word_q == ClassicAbortWord)))
    else $error("abort marker on wrong word");

  // A stashed word flushed to make way for a new word is never marked final
  a_flush_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_stash && wv) |-> !emit_last)
    else $error("stash flushed as final word");

endmodule

`default_nettype wire

>>> rtl/terminal_word_assembler_core.sv
// Top level of the terminal word assembler: byte stream in, word stream out.
// Depends on twa_pkg, twa_front, twa_queue and twa_back.
`default_nettype none

// Takes one host byte per item on the slave stream and delivers 20-bit
// terminal words on the master stream, in classic three-byte framing or in
// ASCII framing, as selected by the start mode register (0 auto-detect,
// 1 classic, 2 ascii, 3 behaves as ascii). A byte is taken every cycle
// unless a replay runs or the queue is full; a word that ends an item is
// output from the cycle after its last byte leaves the queue. In
// auto-detect mode the first three bytes are held without output; the third
// one fixes the framing and the held bytes are replayed through the framing
// logic, which blocks the input during the replay and yields up to three
// words. tlast marks the final word caused by one input byte. Writing the
// configuration register acts as a reconnect and clears all framing state;
// write it only while no item is in flight. The queue depth (QueueDepth)
// sets how far the front end may run ahead of a stalled output.
module terminal_word_assembler_core #(
  parameter int unsigned QueueDepth = twa_pkg::QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write channel: start_mode
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_data_i,
  // input bytes
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  // output words
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [19:0] word, [23:20] zero
  output logic [1:0]  m_axis_tuser_o,   // [0] abort_marker, [1] is_classic
  output logic        m_axis_tlast_o
);
  import twa_pkg::*;

  logic             cfg_write;
  logic             push_valid, push_ready;
  twa_entry_t       push_entry;
  logic             pop_valid, pop_ready;
  twa_entry_t       pop_entry;
  logic [WordW-1:0] word;
  logic             abort_marker, is_classic;

  // Always take configuration writes; they reset the framing at once
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Accept and classify bytes, replay the held detection bytes
  twa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_write_i  (cfg_write),
    .cfg_mode_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_o   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // Decouple the front end from output stalls
  twa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // Assemble words and drive the output register
  twa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_write),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_word_o    (word),
    .m_abort_o   (abort_marker),
    .m_classic_o (is_classic),
    .m_last_o    (m_axis_tlast_o)
  );

  // Pack the word into whole bytes, flags into tuser
  assign m_axis_tdata_o = {4'd0, word};
  assign m_axis_tuser_o = {is_classic, abort_marker};

endmodule

`default_nettype wire
